[sv/radix_digit_converter_macros.svh]
// Assertion macros of the radix digit converter RTL (used by rdc_back).
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

// same-cycle implication
`define RDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/rdc_pkg.sv]
// Shared constants and types of the radix digit converter.
// No dependencies; imported by every RTL module of the block.
package rdc_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int MAX_DIGITS  = 64;
  localparam int DIGIT_LIMIT = (MAX_DIGITS > 64) ? 64 : MAX_DIGITS;
  localparam int CNT_W       = $clog2(DIGIT_LIMIT + 1);
  localparam int ADDR_W      = $clog2(DIGIT_LIMIT);

  localparam int IN_VALUE_W  = 64;
  localparam int RADIX_W     = 5;
  localparam int PREC_W      = 7;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 16;

  // divider consumes STEP_BITS dividend bits per cycle
  localparam int STEP_BITS   = 8;
  localparam int DIV_STEPS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W       = DIV_STEPS * STEP_BITS;
  localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // classified request handed from front to back
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic [CNT_W-1:0]      prec;
    logic                  no_digits;
  } q_item_t;

endpackage

[sv/radix_digit_converter.sv]
// Flow: a request is registered into the request queue; the divider then fills the digit stack
// one digit at a time while the quotient is nonzero or pad digits are owed to the precision;
// each digit is then read back MSB first and loaded into the output register, waiting while it
// holds an unpopped digit. Throughput: one request at a time in the divider.
// Reset: synchronous active-low; clears letter_case, queue pointers, engine state, output valid.
module radix_digit_converter import rdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [IN_VALUE_W-1:0] in_value,
  input  logic [RADIX_W-1:0]    in_radix,
  input  logic [PREC_W-1:0]     in_min_digits,
  output logic                  empty,
  input  logic                  pop,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit,
  output logic [CNT_W-1:0]      out_digit_count,
  input  logic                  valid,
  output logic                  ready,
  input  logic                  cfg_letter_case
);

  logic    letter_case_r;
  logic    q_full;
  logic    q_push;
  logic    q_empty;
  logic    q_pop;
  q_item_t q_wr_item;
  q_item_t q_rd_item;

  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_case_r <= 1'b0;
    end else if (valid && ready) begin
      letter_case_r <= cfg_letter_case;
    end
  end

  rdc_front u_front (
    .push       (push),
    .value      (in_value),
    .radix      (in_radix),
    .min_digits (in_min_digits),
    .q_full     (q_full),
    .full       (full),
    .q_push     (q_push),
    .q_item     (q_wr_item)
  );

  rdc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  rdc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .letter_case (letter_case_r),
    .q_item      (q_rd_item),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .digit_char  (out_digit_char),
    .last_digit  (out_last_digit),
    .digit_count (out_digit_count)
  );

endmodule

[sv/rdc_front.sv]
// Front end: clamps radix and precision and flags requests with no digits.
// Depends on rdc_pkg; feeds rdc_queue.
module rdc_front import rdc_pkg::*; (
  input  logic                  push,
  input  logic [IN_VALUE_W-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  input  logic [PREC_W-1:0]     min_digits,
  input  logic                  q_full,
  output logic                  full,
  output logic                  q_push,
  output q_item_t               q_item
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_item.value = value[VALUE_BITS-1:0];
    if (radix < RADIX_W'(RADIX_MIN)) begin
      q_item.radix = RADIX_W'(RADIX_MIN);
    end else if (radix > RADIX_W'(RADIX_MAX)) begin
      q_item.radix = RADIX_W'(RADIX_MAX);
    end else begin
      q_item.radix = radix;
    end
    if (min_digits > PREC_W'(DIGIT_LIMIT)) begin
      q_item.prec = CNT_W'(DIGIT_LIMIT);
    end else begin
      q_item.prec = CNT_W'(min_digits);
    end
    // zero with zero precision produces nothing
    q_item.no_digits = (value[VALUE_BITS-1:0] == '0) && (min_digits == '0);
  end

endmodule

[sv/rdc_queue.sv]
// Short request queue between the front end and the conversion engine.
// Depends on rdc_pkg (q_item_t, QDEPTH).
module rdc_queue import rdc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wr_item,
  output logic    full,
  input  logic    pop,
  output q_item_t rd_item,
  output logic    empty
);

  q_item_t             entries_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[sv/rdc_back.sv]
// Conversion engine: iterative divider filling a digit stack, then MSB-first
// emission into the output register. Depends on rdc_pkg and the macro header.
`include "radix_digit_converter_macros.svh"
module rdc_back import rdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             letter_case,
  input  q_item_t          q_item,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [CHAR_W-1:0] digit_char,
  output logic             last_digit,
  output logic [CNT_W-1:0] digit_count
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DIV_W-1:0]    div_r, div_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic [CNT_W-1:0]    prec_r, prec_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;
  logic [CNT_W-1:0]    out_count_r;
  logic [DIGIT_W-1:0]  rd_data_r;

  logic [DIGIT_W-1:0]  dig_mem [DIGIT_LIMIT];
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DIGIT_W-1:0]  wr_data;
  logic                rd_en;
  logic                load_out;

  logic [DIV_W-1:0]    sh;
  logic [DIGIT_W-1:0]  rm;
  logic [DIGIT_W:0]    r5;
  logic                div_zero;
  logic                digit_done;
  logic [DIV_W-1:0]    quot;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                       input logic upper);
    logic [CHAR_W-1:0] dd;
    dd = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      return 7'h30 + dd;
    end
    return (upper ? 7'h41 : 7'h61) + dd - 7'd10;
  endfunction

  // STEP_BITS restoring division steps per cycle; quotient bits shift in at the bottom
  always_comb begin
    sh = div_r;
    rm = rem_r;
    r5 = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r5 = {rm, sh[DIV_W-1]};
      sh = {sh[DIV_W-2:0], 1'b0};
      if (r5 >= radix_r) begin
        rm    = DIGIT_W'(r5 - radix_r);
        sh[0] = 1'b1;
      end else begin
        rm = r5[DIGIT_W-1:0];
      end
    end
  end

  // a quotient already at zero yields a padding zero without division steps
  assign div_zero   = (step_r == '0) && (div_r == '0);
  assign digit_done = div_zero || (step_r == STEP_W'(DIV_STEPS - 1));
  assign quot       = div_zero ? '0 : sh;
  assign load_out   = (state_r == S_OUT) && (!out_valid_r || pop);

  always_comb begin
    state_nxt = state_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    prec_nxt  = prec_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    addr_nxt  = addr_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[ADDR_W-1:0];
    wr_data   = div_zero ? '0 : rm;
    rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (!q_item.no_digits) begin
            div_nxt   = DIV_W'(q_item.value);
            radix_nxt = q_item.radix;
            prec_nxt  = q_item.prec;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (digit_done) begin
          wr_en    = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          div_nxt  = quot;
          rem_nxt  = '0;
          step_nxt = '0;
          if (!(((quot != '0) || (cnt_nxt < prec_r)) && (cnt_nxt < CNT_W'(DIGIT_LIMIT)))) begin
            addr_nxt  = cnt_r[ADDR_W-1:0];
            state_nxt = S_RD;
          end
        end else begin
          div_nxt  = sh;
          rem_nxt  = rm;
          step_nxt = step_r + 1'b1;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          if (addr_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = addr_r - 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !pop;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dig_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= dig_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    prec_r  <= prec_nxt;
    addr_r  <= addr_nxt;
    if (load_out) begin
      out_char_r  <= digit_to_ascii(rd_data_r, letter_case);
      out_last_r  <= (addr_r == '0);
      out_count_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty       = !out_valid_r;
  assign digit_char  = out_char_r;
  assign last_digit  = out_last_r;
  assign digit_count = out_count_r;

  `RDC_ASSERT_IMPL(a_cnt_limit, 1'b1, cnt_r <= CNT_W'(DIGIT_LIMIT), "digit count past limit")
  `RDC_ASSERT_IMPL(a_wr_in_div, wr_en, state_r == S_DIV, "digit stack written outside division")
  `RDC_ASSERT_IMPL(a_pop_idle, q_pop, (state_r == S_IDLE) && !q_empty, "request taken while busy")
  `RDC_ASSERT_NEXT(a_last_idle, load_out && (addr_r == '0), (state_r == S_IDLE) && out_last_r,
                   "last digit not followed by idle")

endmodule
